FILE: hw/rtl/nibble_dictionary_decoder_assert.svh
// ----------------------------------------------------------------------------
// Nibble dictionary decoder assertion macros
// Shared property forms used by the decoder's port checker.
// ----------------------------------------------------------------------------
`ifndef NIBBLE_DICTIONARY_DECODER_ASSERT_SVH
`define NIBBLE_DICTIONARY_DECODER_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ND_ASSERT_HOLD(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("decoder port check failed");

// Next-cycle implication, ignored while reset is asserted.
`define ND_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("decoder port check failed");

// Next-cycle implication that is also checked across reset.
`define ND_ASSERT_NEXT_NR(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("decoder reset check failed");

`endif

FILE: hw/rtl/ndd_pkg.sv
// ----------------------------------------------------------------------------
// Nibble dictionary decoder package
// Widths, register indexes, status codes and shared types of the decoder.
// ----------------------------------------------------------------------------
package ndd_pkg;

  localparam int NIB_W         = 4;
  localparam int BYTE_W        = 8;
  localparam int INUSE_W       = NIB_W + 1;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int SIZE_W        = 32;
  localparam int COUNT_W       = SIZE_W + 1;
  localparam int DICT_ENTRIES_DEF = 15;
  localparam int DICT_MAX      = 16;
  localparam logic [NIB_W-1:0] ESC_RESET = 4'hF;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DICT_LOW  = 3'd0,
    REG_DICT_HIGH = 3'd1,
    REG_DICT_CNT  = 3'd2,
    REG_ESCAPE    = 3'd3,
    REG_EXP_SIZE  = 3'd4
  } cfg_reg_t;

  // Stream status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CODE = 2'd1,
    ST_TRUNC    = 2'd2,
    ST_SIZE     = 2'd3
  } status_t;

  // Decoder phase.
  typedef enum logic [1:0] {
    PH_CODE   = 2'd0,
    PH_LIT_HI = 2'd1,
    PH_LIT_LO = 2'd2
  } phase_t;

  // Per-stream decode state.
  typedef struct packed {
    phase_t            phase;
    logic [NIB_W-1:0]  held;
    status_t           err;
  } dec_state_t;

  // Bytes produced by one packed byte, in order.
  typedef struct packed {
    logic              emit0;
    logic [BYTE_W-1:0] data0;
    logic              emit1;
    logic [BYTE_W-1:0] data1;
  } dec_bytes_t;

  // One result word.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    status_t           status;
    logic              end_mark;
  } result_t;

endpackage

FILE: hw/rtl/ndd_if.sv
// ----------------------------------------------------------------------------
// Nibble dictionary decoder channels
// Valid/ready channels for code input, decoded results and configuration.
// ----------------------------------------------------------------------------
interface ndd_in_if import ndd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] packed_byte;
  logic              final_item;
  logic              single_nibble;

  modport source (output valid, packed_byte, final_item, single_nibble, input ready);
  modport sink   (input valid, packed_byte, final_item, single_nibble, output ready);
endinterface

interface ndd_out_if import ndd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic [1:0]        status;
  logic              end_mark;

  modport source (output valid, out_byte, byte_valid, status, end_mark, input ready);
  modport sink   (input valid, out_byte, byte_valid, status, end_mark, output ready);
endinterface

interface ndd_cfg_if import ndd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

FILE: hw/rtl/ndd_decode.sv
// ----------------------------------------------------------------------------
// Nibble dictionary decoder byte decode
// Decodes the two nibbles of one packed byte against the current state.
// ----------------------------------------------------------------------------
module ndd_decode import ndd_pkg::*; #(
  parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
) (
  input  logic [DICT_ENTRIES*BYTE_W-1:0] dict_i,
  input  logic [NIB_W-1:0]               dict_count_i,
  input  logic [NIB_W-1:0]               escape_i,
  input  dec_state_t                     state_i,
  input  logic [BYTE_W-1:0]              packed_byte_i,
  input  logic                           skip_low_i,
  output dec_state_t                     state_o,
  output dec_bytes_t                     bytes_o
);

  // Result of one nibble step.
  typedef struct packed {
    dec_state_t        st;
    logic              emit;
    logic [BYTE_W-1:0] data;
  } step_t;

  logic [INUSE_W-1:0] in_use;
  logic [BYTE_W-1:0]  look_hi;
  logic [BYTE_W-1:0]  look_lo;
  step_t              step_hi;
  step_t              step_lo;

  // Dictionary entry selected by a code; codes beyond the last entry read zero.
  function automatic logic [BYTE_W-1:0] lookup(logic [DICT_ENTRIES*BYTE_W-1:0] d,
                                               logic [NIB_W-1:0] n);
    logic [BYTE_W-1:0] b;
    b = '0;
    for (int k = 0; k < DICT_ENTRIES; k++) begin
      if (n == NIB_W'(k)) begin
        b = d[BYTE_W*k +: BYTE_W];
      end
    end
    return b;
  endfunction

  // Advance the decode state by one nibble.
  function automatic step_t take(dec_state_t s, logic [NIB_W-1:0] n,
                                 logic [NIB_W-1:0] esc, logic [INUSE_W-1:0] lim,
                                 logic [BYTE_W-1:0] lk);
    step_t r;
    r.st   = s;
    r.emit = 1'b0;
    r.data = '0;
    if (s.err == ST_OK) begin
      case (s.phase)
        PH_LIT_HI: begin
          r.st.held  = n;
          r.st.phase = PH_LIT_LO;
        end
        PH_LIT_LO: begin
          r.data     = {s.held, n};
          r.emit     = 1'b1;
          r.st.phase = PH_CODE;
        end
        default: begin
          r.st.phase = PH_CODE;
          if (n == esc) begin
            r.st.phase = PH_LIT_HI;
          end else if ({1'b0, n} < lim) begin
            r.emit = 1'b1;
            r.data = lk;
          end else begin
            r.st.err = ST_BAD_CODE;
          end
        end
      endcase
    end
    return r;
  endfunction

  // Entries in use are limited by the dictionary size.
  assign in_use = ({1'b0, dict_count_i} < INUSE_W'(DICT_ENTRIES)) ?
                  {1'b0, dict_count_i} : INUSE_W'(DICT_ENTRIES);

  assign look_hi = lookup(dict_i, packed_byte_i[BYTE_W-1 -: NIB_W]);
  assign look_lo = lookup(dict_i, packed_byte_i[NIB_W-1:0]);

  // High nibble first, then the low nibble unless it is absent.
  always_comb begin
    step_hi = take(state_i, packed_byte_i[BYTE_W-1 -: NIB_W], escape_i, in_use, look_hi);
    step_lo = take(step_hi.st, packed_byte_i[NIB_W-1:0], escape_i, in_use, look_lo);
    if (skip_low_i) begin
      step_lo = '0;
      step_lo.st = step_hi.st;
    end
    state_o       = step_lo.st;
    bytes_o.emit0 = step_hi.emit;
    bytes_o.data0 = step_hi.data;
    bytes_o.emit1 = step_lo.emit;
    bytes_o.data1 = step_lo.data;
  end

endmodule

FILE: hw/rtl/nibble_dictionary_decoder.sv
// ----------------------------------------------------------------------------
// Nibble dictionary decoder
// Decodes packed 4-bit dictionary and escape codes into a byte stream.
// ----------------------------------------------------------------------------
// A result is queued when its packed byte is accepted and offered from the queue head.
// Throughput: one packed byte per cycle while each byte yields at most one
// result and the output is not stalled; a byte that yields two results puts
// both into a four-entry result queue, read one word per cycle when not stalled.
// Reset (synchronous, active low) resets stream state and configuration and
// empties the result queue; ready is low during reset and goes high as soon
// as reset is released.
module nibble_dictionary_decoder import ndd_pkg::*; #(
  parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ndd_in_if.sink     in_ch,
  ndd_out_if.source  out_ch,
  ndd_cfg_if.sink    cfg_ch
);

  localparam int Q_DEPTH = 4;
  localparam int PTR_W   = $clog2(Q_DEPTH);
  localparam int FILL_W  = PTR_W + 1;

  // Configuration registers.
  logic [DICT_ENTRIES*BYTE_W-1:0] dict_r;
  logic [NIB_W-1:0]               dict_count_r;
  logic [NIB_W-1:0]               escape_r;
  logic [SIZE_W-1:0]              exp_size_r;

  // Stream state.
  dec_state_t         state_r, state_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  // Result queue.
  result_t            q_r [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FILL_W-1:0]  fill_r, fill_nxt;

  dec_state_t         dec_state;
  dec_bytes_t         dec_bytes;
  logic               in_fire;
  logic               out_fire;
  logic               fin;
  logic [1:0]         byte_cnt;
  logic [1:0]         push_n;
  logic [COUNT_W:0]   count_sum;
  logic [COUNT_W-1:0] count_new;
  status_t            end_status;
  result_t            ent0, ent1;

  assign cfg_ch.ready = rst_n;
  assign in_ch.ready  = rst_n && (fill_r <= FILL_W'(Q_DEPTH - 2));
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_ch.valid && out_ch.ready;
  assign fin          = in_ch.final_item;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dict_r       <= '0;
      dict_count_r <= '0;
      escape_r     <= ESC_RESET;
      exp_size_r   <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      for (int k = 0; k < DICT_ENTRIES; k++) begin
        if ((k < 8 && cfg_ch.reg_index == REG_DICT_LOW) ||
            (k >= 8 && cfg_ch.reg_index == REG_DICT_HIGH)) begin
          dict_r[BYTE_W*k +: BYTE_W] <= cfg_ch.wdata[BYTE_W*(k%8) +: BYTE_W];
        end
      end
      if (cfg_ch.reg_index == REG_DICT_CNT) begin
        dict_count_r <= cfg_ch.wdata[NIB_W-1:0];
      end
      if (cfg_ch.reg_index == REG_ESCAPE) begin
        escape_r <= cfg_ch.wdata[NIB_W-1:0];
      end
      if (cfg_ch.reg_index == REG_EXP_SIZE) begin
        exp_size_r <= cfg_ch.wdata[SIZE_W-1:0];
      end
    end
  end

  // Nibble decode of the incoming byte.
  ndd_decode #(
    .DICT_ENTRIES (DICT_ENTRIES)
  ) u_decode (
    .dict_i        (dict_r),
    .dict_count_i  (dict_count_r),
    .escape_i      (escape_r),
    .state_i       (state_r),
    .packed_byte_i (in_ch.packed_byte),
    .skip_low_i    (in_ch.final_item && in_ch.single_nibble),
    .state_o       (dec_state),
    .bytes_o       (dec_bytes)
  );

  // Byte count with saturation, and the end-of-stream status.
  always_comb begin
    byte_cnt  = 2'(dec_bytes.emit0) + 2'(dec_bytes.emit1);
    count_sum = {1'b0, count_r} + (COUNT_W+1)'(byte_cnt);
    count_new = count_sum[COUNT_W] ? '1 : count_sum[COUNT_W-1:0];
    if (dec_state.err != ST_OK) begin
      end_status = dec_state.err;
    end else if (dec_state.phase != PH_CODE) begin
      end_status = ST_TRUNC;
    end else if (count_new != {1'b0, exp_size_r}) begin
      end_status = ST_SIZE;
    end else begin
      end_status = ST_OK;
    end
  end

  // Result words for this byte; the last one of a stream carries status.
  always_comb begin
    push_n = (fin && byte_cnt == 2'd0) ? 2'd1 : byte_cnt;

    ent0            = '0;
    ent0.byte_valid = (byte_cnt != 2'd0);
    ent0.out_byte   = dec_bytes.emit0 ? dec_bytes.data0 :
                      (dec_bytes.emit1 ? dec_bytes.data1 : '0);
    ent0.status     = ST_OK;
    if (fin && byte_cnt != 2'd2) begin
      ent0.status   = end_status;
      ent0.end_mark = 1'b1;
    end

    ent1            = '0;
    ent1.byte_valid = 1'b1;
    ent1.out_byte   = dec_bytes.data1;
    ent1.status     = fin ? end_status : ST_OK;
    ent1.end_mark   = fin;
  end

  // Stream state update; a final byte returns the stream to its start.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    if (in_fire) begin
      if (fin) begin
        state_nxt = '{phase: PH_CODE, held: '0, err: ST_OK};
        count_nxt = '0;
      end else begin
        state_nxt = dec_state;
        count_nxt = count_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_CODE, held: '0, err: ST_OK};
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Result queue control.
  assign fill_nxt = fill_r + (in_fire ? FILL_W'(push_n) : '0) - FILL_W'(out_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (in_fire) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (push_n != 2'd0) begin
        q_r[wr_ptr_r] <= ent0;
      end
      if (push_n == 2'd2) begin
        q_r[wr_ptr_r + PTR_W'(1)] <= ent1;
      end
    end
  end

  // Output port from the queue head.
  assign out_ch.valid      = (fill_r != '0);
  assign out_ch.out_byte   = q_r[rd_ptr_r].out_byte;
  assign out_ch.byte_valid = q_r[rd_ptr_r].byte_valid;
  assign out_ch.status     = q_r[rd_ptr_r].status;
  assign out_ch.end_mark   = q_r[rd_ptr_r].end_mark;

endmodule

FILE: hw/rtl/ndd_checker.sv
// ----------------------------------------------------------------------------
// Nibble dictionary decoder port checker
// Checks result channel behavior seen at the decoder's ports.
// ----------------------------------------------------------------------------
`include "nibble_dictionary_decoder_assert.svh"

module ndd_checker import ndd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_byte,
  input logic              out_byte_valid,
  input logic [1:0]        out_status,
  input logic              out_end_mark
);

  logic [BYTE_W+3:0] out_word;

  // All result fields as one word.
  assign out_word = {out_byte, out_byte_valid, out_status, out_end_mark};

  // A stalled result stays offered and unchanged.
  `ND_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `ND_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_word))

  // A word without a byte only closes a stream.
  `ND_ASSERT_HOLD(a_empty_is_end, out_valid && !out_byte_valid, out_end_mark)

  // Only the closing word carries a status.
  `ND_ASSERT_HOLD(a_status_on_end, out_valid && out_status != ST_OK, out_end_mark)

  // Reset empties the result queue.
  `ND_ASSERT_NEXT_NR(a_reset_empty, !rst_n, !out_valid)

endmodule

bind nibble_dictionary_decoder ndd_checker u_ndd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_byte       (out_ch.out_byte),
  .out_byte_valid (out_ch.byte_valid),
  .out_status     (out_ch.status),
  .out_end_mark   (out_ch.end_mark)
);
